// File: rtl/core/ofcd_pkg.sv
// Package for the occupancy frontier cell detector.
// Holds the cell class type, register indexes, default sizes and the size clamp.
// No dependencies.
package ofcd_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned CFG_W   = 11;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned OUT_W   = 24;

  localparam logic [VALUE_W-1:0] VALUE_UNKNOWN = 8'hFF;
  localparam logic [VALUE_W-1:0] VALUE_FREE    = 8'h00;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;
  localparam int unsigned      DIM_MIN   = 3;

  typedef enum logic [1:0] {
    CLS_OCCUPIED = 2'd0,
    CLS_UNKNOWN  = 2'd1,
    CLS_FREE     = 2'd2
  } cls_t;

  typedef enum logic {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_t;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned val;
    val = {{(32-CFG_W){1'b0}}, v};
    if (val < DIM_MIN) begin
      return DIM_MIN;
    end
    if (val > maxv) begin
      return maxv;
    end
    return val;
  endfunction

  function automatic cls_t classify(input logic [VALUE_W-1:0] v);
    if (v == VALUE_UNKNOWN) begin
      return CLS_UNKNOWN;
    end
    if (v == VALUE_FREE) begin
      return CLS_FREE;
    end
    return CLS_OCCUPIED;
  endfunction

endpackage

// File: rtl/core/occupancy_frontier_cell_detect.sv
// Frontier cell detector over a raster-ordered occupancy grid stream.
// Uses ofcd_pkg for cell classes, register indexes and the size clamp.
//
//   channel  | group                     | request carries
//   ---------+---------------------------+---------------------------------------
//   input    | in_tvalid/tready/tdata    | occupancy_value
//   result   | out_tvalid/tready/tdata   | is_frontier, cell_x, cell_y; tlast
//   config   | cfg_we/cfg_addr/cfg_wdata | map_width (0), map_height (1)
//
// One cell is accepted per cycle while the result is not stalled; an interior cell's result is
// registered in order: first the line buffer read, then the window update.
// The two line buffers share one memory of MAX_WIDTH words, read at the accepted
// column and written back when the cell leaves the read stage.
// rst_n clears the counters, the pipeline valids and the window; the line buffer
// memory is not cleared. A stalled result holds the window stage and the input.
module occupancy_frontier_cell_detect #(
  parameter int unsigned MAX_WIDTH  = ofcd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ofcd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [7:0] occupancy_value
  input  logic [ofcd_pkg::VALUE_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] is_frontier, [10:1] cell_x, [20:11] cell_y, [23:21] zero
  output logic [ofcd_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [ofcd_pkg::CFG_W-1:0]   cfg_wdata
);
  import ofcd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam logic [CW-1:0] W_LAST_RST = CW'(clamp_dim(DIM_RESET, MAX_WIDTH) - 1);
  localparam logic [RW-1:0] H_LAST_RST = RW'(clamp_dim(DIM_RESET, MAX_HEIGHT) - 1);

  logic [CW-1:0] w_last_r;
  logic [RW-1:0] h_last_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [3:0] lbuf_mem [MAX_WIDTH];
  logic [3:0] rd_r;

  logic               s1_valid_r;
  cls_t               s1_cls_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_emit_r;
  logic               s1_last_r;
  logic [COORD_W-1:0] s1_x_r;
  logic [COORD_W-1:0] s1_y_r;

  cls_t win_r [9];
  cls_t win_nxt [9];
  logic frontier;

  logic               out_valid_r;
  logic               out_frontier_r;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic               out_last_r;

  logic in_acc;
  logic adv;
  logic s1_adv;
  cls_t in_cls;

  assign adv       = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign in_cls    = classify(in_tdata);

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (col_r >= w_last_r) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_last_r) ? '0 : row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= W_LAST_RST;
      h_last_r <= H_LAST_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAP_WIDTH: begin
          w_last_r <= CW'(clamp_dim(cfg_wdata, MAX_WIDTH) - 1);
        end
        REG_MAP_HEIGHT: begin
          h_last_r <= RW'(clamp_dim(cfg_wdata, MAX_HEIGHT) - 1);
        end
        default: begin
        end
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Word layout: [3:2] row two above, [1:0] row just above.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= lbuf_mem[col_r];
    end
    if (s1_adv) begin
      lbuf_mem[s1_col_r] <= {rd_r[1:0], s1_cls_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cls_r  <= in_cls;
      s1_col_r  <= col_r;
      s1_emit_r <= (col_r >= CW'(2)) && (row_r >= RW'(2));
      s1_last_r <= (col_r == w_last_r) && (row_r == h_last_r);
      s1_x_r    <= COORD_W'({{(32-CW){1'b0}}, col_r} - 32'd1);
      s1_y_r    <= COORD_W'({{(32-RW){1'b0}}, row_r} - 32'd1);
    end
  end

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = cls_t'(rd_r[3:2]);
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = cls_t'(rd_r[1:0]);
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_cls_r;
    frontier = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4 && win_nxt[i] == CLS_UNKNOWN) begin
        frontier = 1'b1;
      end
    end
    frontier = frontier && (win_nxt[4] == CLS_FREE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= CLS_OCCUPIED;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_frontier_r <= frontier;
      out_x_r        <= s1_x_r;
      out_y_r        <= s1_y_r;
      out_last_r     <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_y_r, out_x_r, out_frontier_r};
  assign out_tlast  = out_last_r;

endmodule
